// ===== rtl/tpcr_pkg.sv =====
// ---------------------------------------------------------------------------
// tpcr_pkg: shared types for the three-point circle radius block
// Holds the fixed radius width and the tag that travels beside the data.
// ---------------------------------------------------------------------------
package tpcr_pkg;

	localparam int RAD_W = 32;

	// Control that rides down the pipeline next to each beat.
	typedef struct packed {
		logic valid;
		logic collinear;
	} tag_t;

endpackage

// ===== rtl/tpcr_if.sv =====
// ---------------------------------------------------------------------------
// tpcr_in_if / tpcr_out_if: valid-ready channels of the radius block
// The input channel carries one point triple per beat, the output one radius.
// ---------------------------------------------------------------------------
interface tpcr_in_if #(parameter int COORD_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] first_x;
	logic signed [COORD_WIDTH-1:0] first_y;
	logic signed [COORD_WIDTH-1:0] second_x;
	logic signed [COORD_WIDTH-1:0] second_y;
	logic signed [COORD_WIDTH-1:0] third_x;
	logic signed [COORD_WIDTH-1:0] third_y;

	modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
		input ready);
	modport sink (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
		output ready);
endinterface

interface tpcr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] radius;
	logic        collinear;
	logic        saturated;

	modport source (output valid, radius, collinear, saturated, input ready);
	modport sink (input valid, radius, collinear, saturated, output ready);
endinterface

// ===== rtl/tpcr_front.sv =====
// ---------------------------------------------------------------------------
// tpcr_front: bisector terms, determinant and squared centre offset
// Ten register stages that turn a point triple into 4*N and |det|.
// ---------------------------------------------------------------------------
module tpcr_front #(
	parameter int W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic signed [W-1:0]   x0,
	input  logic signed [W-1:0]   y0,
	input  logic signed [W-1:0]   x1,
	input  logic signed [W-1:0]   y1,
	input  logic signed [W-1:0]   x2,
	input  logic signed [W-1:0]   y2,
	output tpcr_pkg::tag_t        tag,
	output logic [6*W+7:0]        rad,
	output logic [2*W+1:0]        dmag
);
	import tpcr_pkg::*;

	localparam int DW   = W + 1;
	localparam int SW   = 2 * W + 1;
	localparam int SH   = (SW + 1) / 2;
	localparam int PPW  = DW + SH + 1;
	localparam int AW   = 3 * W + 3;
	localparam int CW   = 3 * W + 2;
	localparam int HH   = (CW + 1) / 2;
	localparam int NW   = 6 * W + 5;
	localparam int RW   = 6 * W + 8;
	localparam int MDW  = 2 * W + 2;
	localparam int DETW = 2 * W + 3;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic col_s4, col_s5, col_s6, col_s7, col_s8, col_s9, col_s10;

	logic signed [DW-1:0] u1_s1, v1_s1, u2_s1, v2_s1;
	logic signed [DW-1:0] u1_s2, v1_s2, u2_s2, v2_s2;
	logic signed [DW-1:0] u1_s3, v1_s3, u2_s3, v2_s3;
	logic signed [2*DW-1:0] uu1_s2, vv1_s2, uu2_s2, vv2_s2, pa_s2, pb_s2;
	logic [SW-1:0] sa_s3, sb_s3;
	logic signed [DETW-1:0] det_s3;
	logic signed [PPW-1:0] ah_s4, al_s4, bh_s4, bl_s4, ch_s4, cl_s4, eh_s4, el_s4;
	logic signed [AW-1:0] a_s5, b_s5, c_s5, e_s5;
	logic signed [AW-1:0] cx_s6, cy_s6;
	logic [2*HH-1:0] cxm_s7, cym_s7;
	logic [2*HH-1:0] xhh_s8, xhl_s8, xll_s8, yhh_s8, yhl_s8, yll_s8;
	logic [2*CW-1:0] cx2_s9, cy2_s9;
	logic [RW-1:0] rad_s10;
	logic [MDW-1:0] dm_s4, dm_s5, dm_s6, dm_s7, dm_s8, dm_s9, dm_s10;

	logic [2*DW-1:0]   sum_a, sum_b;
	logic signed [DETW-1:0] det_c, det_neg;
	logic [2*SH-1:0]   sa_pad, sb_pad;
	logic signed [AW-1:0] cx_neg, cy_neg;
	logic [4*HH-1:0]   cx2_c, cy2_c;
	logic [NW-1:0]     n_c;

	always_comb begin
		sum_a  = uu1_s2 + vv1_s2;
		sum_b  = uu2_s2 + vv2_s2;
		det_c  = (DETW'(pa_s2) - DETW'(pb_s2)) <<< 1;
		det_neg = -det_s3;
		sa_pad = (2*SH)'(sa_s3);
		sb_pad = (2*SH)'(sb_s3);
		cx_neg = -cx_s6;
		cy_neg = -cy_s6;
		// The high-high and low-low partials do not overlap, so they concatenate.
		cx2_c  = {xhh_s8, xll_s8} + ((4*HH)'(xhl_s8) << (HH + 1));
		cy2_c  = {yhh_s8, yll_s8} + ((4*HH)'(yhl_s8) << (HH + 1));
		n_c    = NW'(cx2_s9) + NW'(cy2_s9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: move the origin to the first point.
			u1_s1 <= DW'(x1) - DW'(x0);
			v1_s1 <= DW'(y1) - DW'(y0);
			u2_s1 <= DW'(x2) - DW'(x0);
			v2_s1 <= DW'(y2) - DW'(y0);
			// Stage 2: squares and cross products.
			uu1_s2 <= u1_s1 * u1_s1;
			vv1_s2 <= v1_s1 * v1_s1;
			uu2_s2 <= u2_s1 * u2_s1;
			vv2_s2 <= v2_s1 * v2_s1;
			pa_s2  <= u1_s1 * v2_s1;
			pb_s2  <= v1_s1 * u2_s1;
			{u1_s2, v1_s2, u2_s2, v2_s2} <= {u1_s1, v1_s1, u2_s1, v2_s1};
			// Stage 3: squared lengths and determinant.
			sa_s3  <= sum_a[SW-1:0];
			sb_s3  <= sum_b[SW-1:0];
			det_s3 <= det_c;
			{u1_s3, v1_s3, u2_s3, v2_s3} <= {u1_s2, v1_s2, u2_s2, v2_s2};
			// Stage 4: half-width partial products of the bisector terms.
			ah_s4  <= v2_s3 * $signed({1'b0, sa_pad[2*SH-1:SH]});
			al_s4  <= v2_s3 * $signed({1'b0, sa_pad[SH-1:0]});
			bh_s4  <= v1_s3 * $signed({1'b0, sb_pad[2*SH-1:SH]});
			bl_s4  <= v1_s3 * $signed({1'b0, sb_pad[SH-1:0]});
			ch_s4  <= u1_s3 * $signed({1'b0, sb_pad[2*SH-1:SH]});
			cl_s4  <= u1_s3 * $signed({1'b0, sb_pad[SH-1:0]});
			eh_s4  <= u2_s3 * $signed({1'b0, sa_pad[2*SH-1:SH]});
			el_s4  <= u2_s3 * $signed({1'b0, sa_pad[SH-1:0]});
			col_s4 <= (det_s3 == '0);
			dm_s4  <= det_s3[DETW-1] ? det_neg[MDW-1:0] : det_s3[MDW-1:0];
			// Stage 5: recombine partials.
			a_s5 <= (AW'(ah_s4) <<< SH) + AW'(al_s4);
			b_s5 <= (AW'(bh_s4) <<< SH) + AW'(bl_s4);
			c_s5 <= (AW'(ch_s4) <<< SH) + AW'(cl_s4);
			e_s5 <= (AW'(eh_s4) <<< SH) + AW'(el_s4);
			// Stage 6: centre offset times the determinant.
			cx_s6 <= a_s5 - b_s5;
			cy_s6 <= c_s5 - e_s5;
			// Stage 7: magnitudes.
			cxm_s7 <= (2*HH)'(cx_s6[AW-1] ? cx_neg[CW-1:0] : cx_s6[CW-1:0]);
			cym_s7 <= (2*HH)'(cy_s6[AW-1] ? cy_neg[CW-1:0] : cy_s6[CW-1:0]);
			// Stage 8: partial products of the squares.
			xhh_s8 <= cxm_s7[2*HH-1:HH] * cxm_s7[2*HH-1:HH];
			xhl_s8 <= cxm_s7[2*HH-1:HH] * cxm_s7[HH-1:0];
			xll_s8 <= cxm_s7[HH-1:0] * cxm_s7[HH-1:0];
			yhh_s8 <= cym_s7[2*HH-1:HH] * cym_s7[2*HH-1:HH];
			yhl_s8 <= cym_s7[2*HH-1:HH] * cym_s7[HH-1:0];
			yll_s8 <= cym_s7[HH-1:0] * cym_s7[HH-1:0];
			// Stage 9: full squares.
			cx2_s9 <= cx2_c[2*CW-1:0];
			cy2_s9 <= cy2_c[2*CW-1:0];
			// Stage 10: radicand 4*N.
			rad_s10 <= RW'({n_c, 2'b00});
			{col_s5, col_s6, col_s7, col_s8, col_s9, col_s10} <=
				{col_s4, col_s5, col_s6, col_s7, col_s8, col_s9};
			{dm_s5, dm_s6, dm_s7, dm_s8, dm_s9, dm_s10} <=
				{dm_s4, dm_s5, dm_s6, dm_s7, dm_s8, dm_s9};
		end
	end

	assign tag  = '{valid: v_s10, collinear: col_s10};
	assign rad  = rad_s10;
	assign dmag = dm_s10;

endmodule

// ===== rtl/tpcr_sqrt.sv =====
// ---------------------------------------------------------------------------
// tpcr_sqrt: pipelined integer square root
// One root bit per register stage, digit by digit from the top.
// ---------------------------------------------------------------------------
module tpcr_sqrt #(
	parameter int W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  tpcr_pkg::tag_t       tag_in,
	input  logic [6*W+7:0]       rad,
	input  logic [2*W+1:0]       dmag_in,
	output tpcr_pkg::tag_t       tag_out,
	output logic [3*W+3:0]       root,
	output logic [2*W+1:0]       dmag_out
);
	import tpcr_pkg::*;

	localparam int SQW = 3 * W + 4;
	localparam int RW  = 2 * SQW;
	localparam int MDW = 2 * W + 2;

	logic           vld_s [SQW];
	logic           col_s [SQW];
	logic [RW-1:0]  rad_s [SQW];
	logic [SQW+1:0] rem_s [SQW];
	logic [SQW-1:0] root_s [SQW];
	logic [MDW-1:0] dm_s [SQW];

	for (genvar k = 0; k < SQW; k++) begin : g_step
		logic           v_i, c_i;
		logic [RW-1:0]  rad_i;
		logic [SQW+1:0] rem_i, r2, trial;
		logic [SQW-1:0] root_i;
		logic [MDW-1:0] dm_i;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_i    = tag_in.valid;
			assign c_i    = tag_in.collinear;
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign dm_i   = dmag_in;
		end else begin : g_next
			assign v_i    = vld_s[k-1];
			assign c_i    = col_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign dm_i   = dm_s[k-1];
		end

		always_comb begin
			r2    = {rem_i[SQW-1:0], rad_i[RW-1 -: 2]};
			trial = {root_i, 2'b01};
			ge    = (r2 >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				col_s[k]  <= c_i;
				dm_s[k]   <= dm_i;
				rad_s[k]  <= {rad_i[RW-3:0], 2'b00};
				rem_s[k]  <= ge ? r2 - trial : r2;
				root_s[k] <= {root_i[SQW-2:0], ge};
			end
		end
	end

	assign tag_out  = '{valid: vld_s[SQW-1], collinear: col_s[SQW-1]};
	assign root     = root_s[SQW-1];
	assign dmag_out = dm_s[SQW-1];

endmodule

// ===== rtl/tpcr_div.sv =====
// ---------------------------------------------------------------------------
// tpcr_div: pipelined restoring divider
// Divides the root by |det|, one quotient bit per register stage.
// ---------------------------------------------------------------------------
module tpcr_div #(
	parameter int W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  tpcr_pkg::tag_t       tag_in,
	input  logic [3*W+3:0]       num,
	input  logic [2*W+1:0]       den,
	output tpcr_pkg::tag_t       tag_out,
	output logic [3*W+3:0]       quo
);
	import tpcr_pkg::*;

	localparam int SQW = 3 * W + 4;
	localparam int MDW = 2 * W + 2;

	logic           vld_s [SQW];
	logic           col_s [SQW];
	logic [SQW-1:0] num_s [SQW];
	logic [SQW-1:0] quo_s [SQW];
	logic [MDW:0]   rem_s [SQW];
	logic [MDW-1:0] den_s [SQW];

	for (genvar k = 0; k < SQW; k++) begin : g_step
		logic           v_i, c_i, ge;
		logic [SQW-1:0] num_i, quo_i;
		logic [MDW:0]   rem_i, r2, dext;
		logic [MDW-1:0] den_i;

		if (k == 0) begin : g_first
			assign v_i   = tag_in.valid;
			assign c_i   = tag_in.collinear;
			assign num_i = num;
			assign quo_i = '0;
			assign rem_i = '0;
			assign den_i = den;
		end else begin : g_next
			assign v_i   = vld_s[k-1];
			assign c_i   = col_s[k-1];
			assign num_i = num_s[k-1];
			assign quo_i = quo_s[k-1];
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
		end

		always_comb begin
			r2   = {rem_i[MDW-1:0], num_i[SQW-1]};
			dext = {1'b0, den_i};
			ge   = (r2 >= dext);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				col_s[k] <= c_i;
				den_s[k] <= den_i;
				num_s[k] <= {num_i[SQW-2:0], 1'b0};
				rem_s[k] <= ge ? r2 - dext : r2;
				quo_s[k] <= {quo_i[SQW-2:0], ge};
			end
		end
	end

	assign tag_out = '{valid: vld_s[SQW-1], collinear: col_s[SQW-1]};
	assign quo     = quo_s[SQW-1];

endmodule

// ===== rtl/three_point_circle_radius.sv =====
// ---------------------------------------------------------------------------
// three_point_circle_radius: radius of the circle through three points
// Fully pipelined exact circumradius with rounding and saturation.
// ---------------------------------------------------------------------------
// The block accepts one point triple per clock cycle while ready is high
// and returns one radius per triple, in order, rounded to the nearest output
// step with ties upward. Ten stages form the determinant and the squared
// centre offset, then a square root and a divider each resolve one bit per
// stage over 3*COORD_WIDTH+4 stages, and an output register follows.
// Collinear points give an all-ones radius with collinear set; a radius
// beyond 32 bits gives all ones with saturated set. When the output stalls,
// one more beat is taken into a skid register before the input deasserts
// ready.
module three_point_circle_radius #(
	parameter int COORD_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	tpcr_in_if.sink    points,
	tpcr_out_if.source result
);
	import tpcr_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int SQW = 3 * W + 4;
	localparam int XW  = (SQW > RAD_W) ? SQW : RAD_W + 1;

	typedef struct packed {
		logic [RAD_W-1:0] radius;
		logic             collinear;
		logic             saturated;
	} res_t;

	logic            en;
	tag_t            f_tag, s_tag, d_tag;
	logic [6*W+7:0]  f_rad;
	logic [2*W+1:0]  f_dm, s_dm;
	logic [SQW-1:0]  s_root, d_quo;
	logic [SQW:0]    qp;
	logic [XW-1:0]   rx;
	logic            sat;
	res_t            fin;
	res_t            out_q, skid_q;
	logic            out_valid_q, skid_valid_q;

	assign en           = !skid_valid_q;
	assign points.ready = en;

	tpcr_front #(.W(W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (points.valid),
		.x0       (points.first_x),
		.y0       (points.first_y),
		.x1       (points.second_x),
		.y1       (points.second_y),
		.x2       (points.third_x),
		.y2       (points.third_y),
		.tag      (f_tag),
		.rad      (f_rad),
		.dmag     (f_dm)
	);

	tpcr_sqrt #(.W(W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.tag_in   (f_tag),
		.rad      (f_rad),
		.dmag_in  (f_dm),
		.tag_out  (s_tag),
		.root     (s_root),
		.dmag_out (s_dm)
	);

	tpcr_div #(.W(W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (s_tag),
		.num     (s_root),
		.den     (s_dm),
		.tag_out (d_tag),
		.quo     (d_quo)
	);

	// The rounded radius is the largest r with 2r-1 <= floor(root/|det|).
	always_comb begin
		qp  = {1'b0, d_quo} + (SQW+1)'(1);
		rx  = XW'(qp[SQW:1]);
		sat = |rx[XW-1:RAD_W];
		fin.collinear = d_tag.collinear;
		fin.saturated = sat && !d_tag.collinear;
		fin.radius    = (d_tag.collinear || sat) ? {RAD_W{1'b1}} : rx[RAD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= d_tag.valid;
			end
		end else if (en && d_tag.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || result.ready) begin
			out_q <= skid_valid_q ? skid_q : fin;
		end else if (en && d_tag.valid) begin
			skid_q <= fin;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.radius    = out_q.radius;
	assign result.collinear = out_q.collinear;
	assign result.saturated = out_q.saturated;

endmodule
